// ===== rtl/awm_pkg.sv =====
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types and constants for the sliding-window anagram matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

  localparam int BYTE_W    = 8;
  localparam int SLOTS     = 8;                 // byte slots in a 64-bit word
  localparam int WORD_W    = BYTE_W * SLOTS;
  localparam int LEN_REG_W = 4;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 8'd1;

  typedef logic [BYTE_W-1:0] byte_t;

  // Control handed to every cell of the window row
  typedef struct packed {
    logic advance;   // take the neighbor's byte this cycle
    logic clear;     // line start: load zero instead of the neighbor's byte
  } cell_ctrl_t;

endpackage

// ===== rtl/awm_cell.sv =====
// ----------------------------------------------------------------------------
// awm_cell
// One window slot: holds a byte, takes its neighbor's byte on advance and
// compares the incoming byte against every pattern byte.
// ----------------------------------------------------------------------------
module awm_cell
  import awm_pkg::*;
#(
  parameter int NPAT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  byte_t                shift_in,
  input  byte_t [NPAT-1:0]     pattern,
  output byte_t                slot,
  output byte_t                slot_next,
  output logic  [NPAT-1:0]     eq
);

  assign slot_next = ctrl.clear ? '0 : shift_in;

  always_comb begin
    for (int p = 0; p < NPAT; p++) begin
      eq[p] = (slot_next == pattern[p]);
    end
  end

  // Hold unless the row advances
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctrl.advance) begin
      slot <= slot_next;
    end
  end

endmodule

// ===== rtl/anagram_window_matcher.sv =====
// ----------------------------------------------------------------------------
// anagram_window_matcher
// Sliding-window anagram search over a byte stream, one byte per item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | in_valid / in_stall  | text_byte, line_start
//  out     | out       | out_valid / out_stall| is_match, window_bytes, any_match
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Rate: one item per cycle while in_stall is low; a result is in the output
//  register in the cycle after acceptance. The rate is set by the cell row
//  shifting once per item and the single compare-and-tally stage feeding it.
//  Reset (rst, synchronous) clears the window, fill count, sticky flag,
//  out_valid, any_match and pattern_chars, and sets pattern_length to one.
//  in_stall is high only while a result waits in the output register and
//  out_stall holds it; a result taken in the same cycle frees the slot.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module anagram_window_matcher
  import awm_pkg::*;
#(
  parameter int PATTERN_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  line_start,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_match,
  output logic [WORD_W-1:0]     window_bytes,
  output logic                  any_match,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  // Configuration registers
  logic [WORD_W-1:0]    pattern_chars;
  logic [LEN_REG_W-1:0] pattern_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= LEN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_CHARS:  pattern_chars  <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_REG_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Effective length: zero reads as one, anything above the row as the row
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  byte_t [PATTERN_MAX-1:0] pat;
  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      pat[p] = pattern_chars[BYTE_W*p +: BYTE_W];
    end
  end

  // Handshake: the output register parts the two sides
  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Cell row: slot 0 holds the newest byte, each slot takes its neighbor's
  cell_ctrl_t                       ctrl [PATTERN_MAX];
  byte_t      [PATTERN_MAX-1:0]     slot;
  byte_t      [PATTERN_MAX-1:0]     slot_next;
  logic       [PATTERN_MAX-1:0]     eq [PATTERN_MAX];   // eq[w][p]

  for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_cell
    byte_t shift_in;
    assign ctrl[w].advance = accept;
    if (w == 0) begin : g_head
      // The new byte enters even on a line start
      assign ctrl[w].clear = 1'b0;
      assign shift_in      = text_byte;
    end else begin : g_body
      assign ctrl[w].clear = line_start;
      assign shift_in      = slot[w-1];
    end

    awm_cell #(
      .NPAT (PATTERN_MAX)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[w]),
      .shift_in  (shift_in),
      .pattern   (pat),
      .slot      (slot[w]),
      .slot_next (slot_next[w]),
      .eq        (eq[w])
    );
  end

  // Fill count, saturating at the row length
  logic [LEN_W-1:0] fill_count;
  logic [LEN_W-1:0] fill_base;
  logic [LEN_W-1:0] fill_next;

  assign fill_base = line_start ? '0 : fill_count;
  assign fill_next = (fill_base == LEN_MAX) ? LEN_MAX : fill_base + LEN_W'(1);

  // Multiset compare: for every live pattern byte, its count in the window
  // must equal its count in the pattern. Equal totals make this sufficient.
  logic match;
  always_comb begin
    logic [LEN_W-1:0] wcnt;
    logic [LEN_W-1:0] pcnt;
    match = (fill_next >= len_eff);
    for (int p = 0; p < PATTERN_MAX; p++) begin
      wcnt = '0;
      pcnt = '0;
      for (int q = 0; q < PATTERN_MAX; q++) begin
        if (q < int'(len_eff)) begin
          if (eq[q][p]) wcnt = wcnt + LEN_W'(1);
          if (pat[q] == pat[p]) pcnt = pcnt + LEN_W'(1);
        end
      end
      if (p < int'(len_eff) && wcnt != pcnt) match = 1'b0;
    end
  end

  // Window bytes, oldest of the last len_eff bytes in the low byte
  logic [WORD_W-1:0] bytes_next;
  always_comb begin
    bytes_next = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      for (int w = 0; w < PATTERN_MAX; w++) begin
        if (i < int'(len_eff) && w == int'(len_eff) - 1 - i) begin
          bytes_next[BYTE_W*i +: BYTE_W] = slot_next[w];
        end
      end
    end
  end

  // State and output register
  logic seen_match;
  logic seen_next;
  assign seen_next = seen_match || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      seen_match <= 1'b0;
      out_valid  <= 1'b0;
      any_match  <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_next;
        seen_match <= seen_next;
        any_match  <= seen_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_match     <= match;
      window_bytes <= bytes_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An empty output register never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall high with empty output register");

  // Every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // A reported match always shows the sticky flag
  a_match_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_match) |-> any_match)
    else $error("is_match without any_match");

  // The sticky flag never falls back once shown
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && any_match) |=> any_match)
    else $error("any_match cleared");
`endif

endmodule
